>>> rtl/rbm_pkg.sv
// ---------------------------------------------------------------------------
// rbm_pkg: shared types and constants of the resource budget meter
// Field widths, class and register codes, status codes and the structs
// that travel between the configuration bank, the cost multiplier and
// the ledger.
// ---------------------------------------------------------------------------
package rbm_pkg;

    // Field widths
    localparam int DATA_W     = 64;
    localparam int HALF_W     = DATA_W / 2;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_ADDR_W = 3;

    // Result packing: status, remaining, system use, credit left, credit spent
    localparam int OUT_FIELDS_W = STATUS_W + 4 * DATA_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TDATA_W   = DATA_W;
    localparam int IN_TUSER_W   = 8;

    // Resource class codes (code three is an ignored request)
    localparam logic [FUNC_W-1:0] CLS_DISK    = 2'd0;
    localparam logic [FUNC_W-1:0] CLS_NETWORK = 2'd1;
    localparam logic [FUNC_W-1:0] CLS_COMPUTE = 2'd2;
    localparam logic [FUNC_W-1:0] CLS_NONE    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DISK_LIMIT     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NETWORK_LIMIT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COMPUTE_LIMIT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DISK_COST      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NETWORK_COST   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COMPUTE_COST   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SESSION_EN     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_START_CREDIT   = 3'd7;

    // Reset values
    localparam logic [DATA_W-1:0] LIMIT_RESET = '1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK               = 3'd0,
        STATUS_DISK_EXCEEDED    = 3'd1,
        STATUS_NETWORK_EXCEEDED = 3'd2,
        STATUS_COMPUTE_EXCEEDED = 3'd3,
        STATUS_NO_CREDIT        = 3'd4,
        STATUS_COST_OVERFLOW    = 3'd5
    } status_t;

    // Configuration register bank contents
    typedef struct packed {
        logic [DATA_W-1:0] disk_limit;
        logic [DATA_W-1:0] network_limit;
        logic [DATA_W-1:0] compute_limit;
        logic [DATA_W-1:0] disk_cost;
        logic [DATA_W-1:0] network_cost;
        logic [DATA_W-1:0] compute_cost;
        logic              session_en;
        logic [DATA_W-1:0] start_credit;
    } cfg_t;

    // Partial products of amount times cost rate
    typedef struct packed {
        logic [DATA_W-1:0] p_ll;
        logic [DATA_W-1:0] p_lh;
        logic [DATA_W-1:0] p_hl;
        logic              both_hi;
    } prod_t;

    // Combined charge
    typedef struct packed {
        logic [DATA_W-1:0] cost;
        logic              ovf;
    } cost_t;

    // One result item
    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] class_remaining;
        logic [DATA_W-1:0] class_system_use;
        logic [DATA_W-1:0] credit_left;
        logic [DATA_W-1:0] credit_spent;
    } result_t;

endpackage

>>> rtl/rbm_cfg_regs.sv
// ---------------------------------------------------------------------------
// rbm_cfg_regs: configuration register bank
// Holds limits, cost rates, session enable and start credit. Every write
// raises a one-cycle reload strobe for the ledger on the following cycle.
// ---------------------------------------------------------------------------
module rbm_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rbm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rbm_pkg::DATA_W-1:0]       cfg_wdata,
    output rbm_pkg::cfg_t                    cfg,
    output logic                             reload
);

    rbm_pkg::cfg_t cfg_reg;
    logic          reload_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.disk_limit    <= rbm_pkg::LIMIT_RESET;
            cfg_reg.network_limit <= rbm_pkg::LIMIT_RESET;
            cfg_reg.compute_limit <= rbm_pkg::LIMIT_RESET;
            cfg_reg.disk_cost     <= '0;
            cfg_reg.network_cost  <= '0;
            cfg_reg.compute_cost  <= '0;
            cfg_reg.session_en    <= 1'b0;
            cfg_reg.start_credit  <= '0;
            reload_reg            <= 1'b0;
        end else begin
            reload_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    rbm_pkg::REG_DISK_LIMIT:    cfg_reg.disk_limit    <= cfg_wdata;
                    rbm_pkg::REG_NETWORK_LIMIT: cfg_reg.network_limit <= cfg_wdata;
                    rbm_pkg::REG_COMPUTE_LIMIT: cfg_reg.compute_limit <= cfg_wdata;
                    rbm_pkg::REG_DISK_COST:     cfg_reg.disk_cost     <= cfg_wdata;
                    rbm_pkg::REG_NETWORK_COST:  cfg_reg.network_cost  <= cfg_wdata;
                    rbm_pkg::REG_COMPUTE_COST:  cfg_reg.compute_cost  <= cfg_wdata;
                    rbm_pkg::REG_SESSION_EN:    cfg_reg.session_en    <= cfg_wdata[0];
                    rbm_pkg::REG_START_CREDIT:  cfg_reg.start_credit  <= cfg_wdata;
                    default:                    cfg_reg.start_credit  <= cfg_reg.start_credit;
                endcase
            end
        end
    end

    assign cfg    = cfg_reg;
    assign reload = reload_reg;

endmodule

>>> rtl/rbm_cost_mult.sv
// ---------------------------------------------------------------------------
// rbm_cost_mult: two-stage charge multiplier
// Stage A forms three 32x32 partial products of amount and class cost
// rate; stage B sums them into a 64-bit cost and flags a product that
// does not fit in 64 bits. Carries class and amount alongside.
// ---------------------------------------------------------------------------
module rbm_cost_mult (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rbm_pkg::cfg_t                  cfg,
    // upstream
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rbm_pkg::FUNC_W-1:0]     in_func,
    input  logic [rbm_pkg::DATA_W-1:0]     in_amount,
    // downstream
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rbm_pkg::FUNC_W-1:0]     out_func,
    output logic [rbm_pkg::DATA_W-1:0]     out_amount,
    output rbm_pkg::cost_t                 out_cost
);

    localparam int HW = rbm_pkg::HALF_W;
    localparam int DW = rbm_pkg::DATA_W;

    logic                          valid_a_reg;
    logic [rbm_pkg::FUNC_W-1:0]    func_a_reg;
    logic [DW-1:0]                 amount_a_reg;
    rbm_pkg::prod_t                prod_a_reg;

    logic                          valid_b_reg;
    logic [rbm_pkg::FUNC_W-1:0]    func_b_reg;
    logic [DW-1:0]                 amount_b_reg;
    rbm_pkg::cost_t                cost_b_reg;

    logic [DW-1:0]                 rate;
    rbm_pkg::prod_t                prod_next;
    rbm_pkg::cost_t                cost_next;
    logic [DW:0]                   cross_sum;
    logic [DW:0]                   low_sum;
    logic                          load_a;
    logic                          adv_b;

    // Stage handshake
    assign adv_b    = valid_a_reg && (!valid_b_reg || out_ready);
    assign in_ready = !valid_a_reg || adv_b;
    assign load_a   = in_valid && in_ready;

    // Cost rate of the requested class
    always_comb begin
        unique case (in_func)
            rbm_pkg::CLS_DISK:    rate = cfg.disk_cost;
            rbm_pkg::CLS_NETWORK: rate = cfg.network_cost;
            rbm_pkg::CLS_COMPUTE: rate = cfg.compute_cost;
            rbm_pkg::CLS_NONE:    rate = '0;
            default:              rate = '0;
        endcase
    end

    // Stage A: partial products (32x32, zero-extended to the full product width)
    always_comb begin
        prod_next.p_ll    = DW'(in_amount[HW-1:0])  * DW'(rate[HW-1:0]);
        prod_next.p_lh    = DW'(in_amount[HW-1:0])  * DW'(rate[DW-1:HW]);
        prod_next.p_hl    = DW'(in_amount[DW-1:HW]) * DW'(rate[HW-1:0]);
        prod_next.both_hi = (|in_amount[DW-1:HW]) && (|rate[DW-1:HW]);
    end

    // Stage B: combine, the high-high product only matters as overflow
    always_comb begin
        cross_sum     = {1'b0, prod_a_reg.p_lh} + {1'b0, prod_a_reg.p_hl};
        low_sum       = {1'b0, prod_a_reg.p_ll} + {1'b0, cross_sum[HW-1:0], {HW{1'b0}}};
        cost_next.cost = low_sum[DW-1:0];
        cost_next.ovf  = prod_a_reg.both_hi || (|cross_sum[DW:HW]) || low_sum[DW];
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (load_a) begin
                valid_a_reg <= 1'b1;
            end else if (adv_b) begin
                valid_a_reg <= 1'b0;
            end
            if (adv_b) begin
                valid_b_reg <= 1'b1;
            end else if (out_ready) begin
                valid_b_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load_a) begin
            func_a_reg   <= in_func;
            amount_a_reg <= in_amount;
            prod_a_reg   <= prod_next;
        end
        if (adv_b) begin
            func_b_reg   <= func_a_reg;
            amount_b_reg <= amount_a_reg;
            cost_b_reg   <= cost_next;
        end
    end

    assign out_valid  = valid_b_reg;
    assign out_func   = func_b_reg;
    assign out_amount = amount_b_reg;
    assign out_cost   = cost_b_reg;

endmodule

>>> rtl/rbm_ledger.sv
// ---------------------------------------------------------------------------
// rbm_ledger: budget counters and charge decision
// Keeps remaining budgets, system-use counters and session credit, checks
// each request combinationally and writes the result into the output register.
// ---------------------------------------------------------------------------
module rbm_ledger (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rbm_pkg::cfg_t                  cfg,
    input  logic                           reload,
    // request with its computed charge
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rbm_pkg::FUNC_W-1:0]     in_func,
    input  logic [rbm_pkg::DATA_W-1:0]     in_amount,
    input  rbm_pkg::cost_t                 in_cost,
    // result
    output logic                           out_valid,
    input  logic                           out_ready,
    output rbm_pkg::result_t               out_result
);

    localparam int DW = rbm_pkg::DATA_W;

    logic [DW-1:0]     disk_left_reg, network_left_reg, compute_left_reg;
    logic [DW-1:0]     disk_sys_reg, network_sys_reg, compute_sys_reg;
    logic [DW-1:0]     credit_reg;
    logic              out_valid_reg;
    rbm_pkg::result_t  result_reg;

    logic [DW-1:0]     left_sel, sys_sel, left_after, sys_after, credit_after;
    logic              cls_valid, over, charge, sys_add, fire;
    rbm_pkg::status_t  exceed_status, status;
    rbm_pkg::result_t  result_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // Counters of the requested class
    always_comb begin
        unique case (in_func)
            rbm_pkg::CLS_DISK: begin
                cls_valid     = 1'b1;
                left_sel      = disk_left_reg;
                sys_sel       = disk_sys_reg;
                exceed_status = rbm_pkg::STATUS_DISK_EXCEEDED;
                over          = in_amount >= disk_left_reg;
            end
            rbm_pkg::CLS_NETWORK: begin
                cls_valid     = 1'b1;
                left_sel      = network_left_reg;
                sys_sel       = network_sys_reg;
                exceed_status = rbm_pkg::STATUS_NETWORK_EXCEEDED;
                over          = in_amount >= network_left_reg;
            end
            rbm_pkg::CLS_COMPUTE: begin
                cls_valid     = 1'b1;
                left_sel      = compute_left_reg;
                sys_sel       = compute_sys_reg;
                exceed_status = rbm_pkg::STATUS_COMPUTE_EXCEEDED;
                over          = in_amount > compute_left_reg;
            end
            default: begin
                cls_valid     = 1'b0;
                left_sel      = '0;
                sys_sel       = '0;
                exceed_status = rbm_pkg::STATUS_OK;
                over          = 1'b0;
            end
        endcase
    end

    // Charge decision: budget first, then cost overflow, then credit
    always_comb begin
        status  = rbm_pkg::STATUS_OK;
        charge  = 1'b0;
        sys_add = 1'b0;
        if (cls_valid) begin
            if (over) begin
                status = exceed_status;
            end else if (cfg.session_en) begin
                if (in_cost.ovf) begin
                    status = rbm_pkg::STATUS_COST_OVERFLOW;
                end else if (in_cost.cost > credit_reg) begin
                    status = rbm_pkg::STATUS_NO_CREDIT;
                end else begin
                    charge = 1'b1;
                end
            end else begin
                sys_add = 1'b1;
            end
        end
        left_after   = (charge || sys_add) ? left_sel - in_amount : left_sel;
        sys_after    = sys_add ? sys_sel + in_amount : sys_sel;
        credit_after = charge ? credit_reg - in_cost.cost : credit_reg;

        result_next.status           = status;
        result_next.class_remaining  = left_after;
        result_next.class_system_use = sys_after;
        result_next.credit_left      = credit_after;
        result_next.credit_spent     = cfg.start_credit - credit_after;
    end

    // Budget state; a configuration write reloads everything
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_left_reg    <= rbm_pkg::LIMIT_RESET;
            network_left_reg <= rbm_pkg::LIMIT_RESET;
            compute_left_reg <= rbm_pkg::LIMIT_RESET;
            disk_sys_reg     <= '0;
            network_sys_reg  <= '0;
            compute_sys_reg  <= '0;
            credit_reg       <= '0;
        end else if (reload) begin
            disk_left_reg    <= cfg.disk_limit;
            network_left_reg <= cfg.network_limit;
            compute_left_reg <= cfg.compute_limit;
            disk_sys_reg     <= '0;
            network_sys_reg  <= '0;
            compute_sys_reg  <= '0;
            credit_reg       <= cfg.start_credit;
        end else if (fire) begin
            credit_reg <= credit_after;
            unique case (in_func)
                rbm_pkg::CLS_DISK: begin
                    disk_left_reg <= left_after;
                    disk_sys_reg  <= sys_after;
                end
                rbm_pkg::CLS_NETWORK: begin
                    network_left_reg <= left_after;
                    network_sys_reg  <= sys_after;
                end
                rbm_pkg::CLS_COMPUTE: begin
                    compute_left_reg <= left_after;
                    compute_sys_reg  <= sys_after;
                end
                default: begin
                    // ignored request: class counters hold
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

>>> rtl/resource_budget_meter_core.sv
// ---------------------------------------------------------------------------
// resource_budget_meter_core: resource budget meter, top level
// Charges disk, network and compute requests against budgets and an
// optional session credit, one result per request.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the resource class,
//   s_tdata the amount. Each request gives exactly one result on the m_
//   stream with status, remaining budget, system use and session credit.
//   Throughput is one transfer per clock in both directions while m_tready
//   stays high. Three register stages (partial products, summed cost,
//   ledger/output register) lie between the input transfer and m_tvalid;
//   the ledger stage updates the counters as it registers each result, so
//   requests can follow each other back to back.
//   The configuration port writes one register per cycle; any write reloads
//   the budgets and session credit and clears system use on the next cycle.
//   Write it only while no request is in flight.
//   Reset (aresetn low, synchronous) empties the pipeline and restores all
//   configuration registers and counters to their reset values.
//   When the receiver holds m_tready low the result register holds, the
//   two multiplier stages fill, and s_tready then drops.
// ---------------------------------------------------------------------------
module resource_budget_meter_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [rbm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [rbm_pkg::DATA_W-1:0]           cfg_wdata,
    // request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rbm_pkg::IN_TDATA_W-1:0]       s_tdata,  // [63:0] amount
    input  logic [rbm_pkg::IN_TUSER_W-1:0]       s_tuser,  // [1:0] func
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [2:0] status, [66:3] class_remaining, [130:67] class_system_use,
    // [194:131] credit_left, [258:195] credit_spent, rest zero
    output logic [rbm_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    rbm_pkg::cfg_t                  cfg;
    logic                           reload;
    logic                           mult_valid, mult_ready;
    logic [rbm_pkg::FUNC_W-1:0]     mult_func;
    logic [rbm_pkg::DATA_W-1:0]     mult_amount;
    rbm_pkg::cost_t                 mult_cost;
    rbm_pkg::result_t               result;

    rbm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .reload    (reload)
    );

    rbm_cost_mult u_mult (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser[rbm_pkg::FUNC_W-1:0]),
        .in_amount  (s_tdata[rbm_pkg::DATA_W-1:0]),
        .out_valid  (mult_valid),
        .out_ready  (mult_ready),
        .out_func   (mult_func),
        .out_amount (mult_amount),
        .out_cost   (mult_cost)
    );

    rbm_ledger u_ledger (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .reload     (reload),
        .in_valid   (mult_valid),
        .in_ready   (mult_ready),
        .in_func    (mult_func),
        .in_amount  (mult_amount),
        .in_cost    (mult_cost),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result packing, status in the lowest bits
    assign m_tdata = {
        {(rbm_pkg::OUT_TDATA_W - rbm_pkg::OUT_FIELDS_W){1'b0}},
        result.credit_spent,
        result.credit_left,
        result.class_system_use,
        result.class_remaining,
        result.status
    };

endmodule

>>> test/resource_budget_meter_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// resource_budget_meter_core_test: self-checking bench for the budget meter
// Drives charge requests on the request stream and configuration writes
// between phases. A scoreboard predicts each result from its own copy of the
// budgets, system-use counters and session credit, and compares every
// result transfer field by field. Both stream sides idle at random, and the
// result side also holds off for a long stretch to back up the pipeline.
// ---------------------------------------------------------------------------

// Charge predictor and expected-result store
class charge_scoreboard;
    logic [rbm_pkg::DATA_W-1:0] limit_q [3];
    logic [rbm_pkg::DATA_W-1:0] rate_q [3];
    logic                       session_on;
    logic [rbm_pkg::DATA_W-1:0] start_credit;
    logic [rbm_pkg::DATA_W-1:0] budget_left [3];
    logic [rbm_pkg::DATA_W-1:0] sys_used [3];
    logic [rbm_pkg::DATA_W-1:0] credit;
    rbm_pkg::result_t           expected_charges [$];
    int                         errors;

    function new();
        for (int k = 0; k < 3; k++) begin
            limit_q[k] = rbm_pkg::LIMIT_RESET;
            rate_q[k]  = '0;
        end
        session_on   = 1'b0;
        start_credit = '0;
        errors       = 0;
        reload();
    endfunction

    // Any register write restarts the budgets and the session
    function void reload();
        for (int k = 0; k < 3; k++) begin
            budget_left[k] = limit_q[k];
            sys_used[k]    = '0;
        end
        credit = start_credit;
    endfunction

    function void write_register(logic [rbm_pkg::CFG_ADDR_W-1:0] idx,
                                 logic [rbm_pkg::DATA_W-1:0] value);
        case (idx)
            rbm_pkg::REG_DISK_LIMIT:    limit_q[0] = value;
            rbm_pkg::REG_NETWORK_LIMIT: limit_q[1] = value;
            rbm_pkg::REG_COMPUTE_LIMIT: limit_q[2] = value;
            rbm_pkg::REG_DISK_COST:     rate_q[0] = value;
            rbm_pkg::REG_NETWORK_COST:  rate_q[1] = value;
            rbm_pkg::REG_COMPUTE_COST:  rate_q[2] = value;
            rbm_pkg::REG_SESSION_EN:    session_on = value[0];
            rbm_pkg::REG_START_CREDIT:  start_credit = value;
            default: ;
        endcase
        reload();
    endfunction

    // Predict the result of one accepted request and update the ledger
    function void note_charge(logic [rbm_pkg::FUNC_W-1:0] cls,
                              logic [rbm_pkg::DATA_W-1:0] amount);
        rbm_pkg::result_t             want;
        logic [2*rbm_pkg::DATA_W-1:0] product;
        logic                         over;
        int                           k;
        want.status           = rbm_pkg::STATUS_OK;
        want.class_remaining  = '0;
        want.class_system_use = '0;
        if (cls != rbm_pkg::CLS_NONE) begin
            k = int'(cls);
            // compute may spend its whole budget, disk and network may not
            if (cls == rbm_pkg::CLS_COMPUTE)
                over = amount > budget_left[k];
            else
                over = amount >= budget_left[k];
            product = {{rbm_pkg::DATA_W{1'b0}}, amount}
                    * {{rbm_pkg::DATA_W{1'b0}}, rate_q[k]};
            if (over) begin
                case (cls)
                    rbm_pkg::CLS_DISK:    want.status = rbm_pkg::STATUS_DISK_EXCEEDED;
                    rbm_pkg::CLS_NETWORK: want.status = rbm_pkg::STATUS_NETWORK_EXCEEDED;
                    default:              want.status = rbm_pkg::STATUS_COMPUTE_EXCEEDED;
                endcase
            end else if (session_on) begin
                if (product[2*rbm_pkg::DATA_W-1:rbm_pkg::DATA_W] != '0) begin
                    want.status = rbm_pkg::STATUS_COST_OVERFLOW;
                end else if (product[rbm_pkg::DATA_W-1:0] > credit) begin
                    want.status = rbm_pkg::STATUS_NO_CREDIT;
                end else begin
                    credit         -= product[rbm_pkg::DATA_W-1:0];
                    budget_left[k] -= amount;
                end
            end else begin
                sys_used[k]    += amount;
                budget_left[k] -= amount;
            end
            want.class_remaining  = budget_left[k];
            want.class_system_use = sys_used[k];
        end
        want.credit_left  = credit;
        want.credit_spent = start_credit - credit;
        expected_charges.push_back(want);
    endfunction

    function void compare_field(string field, logic [rbm_pkg::DATA_W-1:0] want,
                                logic [rbm_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endfunction

    // Check one result transfer against the oldest prediction
    function void check_charge(logic [rbm_pkg::OUT_TDATA_W-1:0] beat);
        rbm_pkg::result_t want;
        if (expected_charges.size() == 0) begin
            $error("result transfer with nothing expected: %0h", beat);
            errors++;
            return;
        end
        want = expected_charges.pop_front();
        compare_field("status", rbm_pkg::DATA_W'(want.status),
                      rbm_pkg::DATA_W'(beat[rbm_pkg::STATUS_W-1:0]));
        compare_field("class_remaining", want.class_remaining,
                      beat[rbm_pkg::STATUS_W +: rbm_pkg::DATA_W]);
        compare_field("class_system_use", want.class_system_use,
                      beat[rbm_pkg::STATUS_W + rbm_pkg::DATA_W +: rbm_pkg::DATA_W]);
        compare_field("credit_left", want.credit_left,
                      beat[rbm_pkg::STATUS_W + 2*rbm_pkg::DATA_W +: rbm_pkg::DATA_W]);
        compare_field("credit_spent", want.credit_spent,
                      beat[rbm_pkg::STATUS_W + 3*rbm_pkg::DATA_W +: rbm_pkg::DATA_W]);
    endfunction

    function int pending();
        return expected_charges.size();
    endfunction
endclass

module resource_budget_meter_core_test;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [rbm_pkg::DATA_W-1:0] ALL_ONES = {rbm_pkg::DATA_W{1'b1}};

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [rbm_pkg::CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [rbm_pkg::DATA_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [rbm_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;  // [63:0] amount
    logic [rbm_pkg::IN_TUSER_W-1:0]  s_tuser   = '0;  // [1:0] func
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [rbm_pkg::OUT_TDATA_W-1:0] m_tdata;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    charge_scoreboard ledger = new();

    resource_budget_meter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Transfer monitor: predict on input, check on output
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                ledger.note_charge(s_tuser[rbm_pkg::FUNC_W-1:0], s_tdata);
            if (m_tvalid && m_tready)
                ledger.check_charge(m_tdata);
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one request and hold it until the transfer
    task automatic send_charge(logic [rbm_pkg::FUNC_W-1:0] cls,
                               logic [rbm_pkg::DATA_W-1:0] amount);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rbm_pkg::IN_TUSER_W'(cls);
        s_tdata  <= amount;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(logic [rbm_pkg::CFG_ADDR_W-1:0] idx,
                             logic [rbm_pkg::DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        ledger.write_register(idx, value);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // mode 0: all ones, mode 1: all zeros, otherwise mixed random
    function automatic logic [rbm_pkg::DATA_W-1:0] setting_value(int mode, int small_max);
        if (mode == 0)
            return ALL_ONES;
        if (mode == 1)
            return '0;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return {$urandom, $urandom};
            default: return rbm_pkg::DATA_W'($urandom_range(0, small_max));
        endcase
    endfunction

    task automatic apply_setting(int mode);
        logic [rbm_pkg::DATA_W-1:0] en_word;
        wait_drained();
        if (mode == 0)
            en_word = ALL_ONES;
        else if (mode == 1)
            en_word = '0;
        else
            en_word = {$urandom, $urandom};
        write_reg(rbm_pkg::REG_DISK_LIMIT, setting_value(mode, 2000));
        write_reg(rbm_pkg::REG_NETWORK_LIMIT, setting_value(mode, 2000));
        write_reg(rbm_pkg::REG_COMPUTE_LIMIT, setting_value(mode, 2000));
        write_reg(rbm_pkg::REG_DISK_COST, setting_value(mode, 8));
        write_reg(rbm_pkg::REG_NETWORK_COST, setting_value(mode, 8));
        write_reg(rbm_pkg::REG_COMPUTE_COST, setting_value(mode, 8));
        write_reg(rbm_pkg::REG_SESSION_EN, en_word);
        write_reg(rbm_pkg::REG_START_CREDIT, setting_value(mode, 20000));
        end_writes();
    endtask

    function automatic logic [rbm_pkg::FUNC_W-1:0] pick_class();
        if ($urandom_range(0, 19) == 0)
            return rbm_pkg::CLS_NONE;
        return rbm_pkg::FUNC_W'($urandom_range(0, 2));
    endfunction

    // Amounts cluster around the budget and credit edges
    function automatic logic [rbm_pkg::DATA_W-1:0] pick_amount(
        logic [rbm_pkg::FUNC_W-1:0] cls);
        logic [rbm_pkg::DATA_W-1:0] rem;
        logic [rbm_pkg::DATA_W-1:0] rate;
        rem  = '0;
        rate = '0;
        if (cls != rbm_pkg::CLS_NONE) begin
            rem  = ledger.budget_left[cls];
            rate = ledger.rate_q[cls];
        end
        case ($urandom_range(0, 11))
            0: return '0;
            1: return ALL_ONES;
            2: return {$urandom, $urandom};
            3: return rem;
            4: return rem - 1;
            5: return rem + 1;
            6: begin
                if (rate != '0)
                    return ledger.credit / rate + rbm_pkg::DATA_W'($urandom_range(0, 1));
                return rem >> 1;
            end
            default: return rbm_pkg::DATA_W'($urandom_range(0, 300));
        endcase
    endfunction

    initial begin
        logic [rbm_pkg::FUNC_W-1:0] cls;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset budgets, no session
        send_charge(rbm_pkg::CLS_DISK, '0);
        send_charge(rbm_pkg::CLS_DISK, ALL_ONES);
        send_charge(rbm_pkg::CLS_NETWORK, ALL_ONES);
        send_charge(rbm_pkg::CLS_NETWORK, ALL_ONES - 1);
        send_charge(rbm_pkg::CLS_NETWORK, 64'd1);
        send_charge(rbm_pkg::CLS_NETWORK, '0);
        send_charge(rbm_pkg::CLS_COMPUTE, ALL_ONES);
        send_charge(rbm_pkg::CLS_COMPUTE, 64'd1);
        send_charge(rbm_pkg::CLS_COMPUTE, '0);
        send_charge(rbm_pkg::CLS_NONE, {$urandom, $urandom});
        send_charge(rbm_pkg::CLS_DISK, {$urandom, $urandom});

        // Directed: paying session, small budgets
        wait_drained();
        write_reg(rbm_pkg::REG_DISK_LIMIT, 64'd100);
        write_reg(rbm_pkg::REG_NETWORK_LIMIT, 64'd100);
        write_reg(rbm_pkg::REG_COMPUTE_LIMIT, 64'd100);
        write_reg(rbm_pkg::REG_DISK_COST, 64'd3);
        write_reg(rbm_pkg::REG_NETWORK_COST, ALL_ONES);
        write_reg(rbm_pkg::REG_COMPUTE_COST, '0);
        write_reg(rbm_pkg::REG_SESSION_EN, 64'd1);
        write_reg(rbm_pkg::REG_START_CREDIT, 64'd300);
        end_writes();
        send_charge(rbm_pkg::CLS_DISK, 64'd100);
        send_charge(rbm_pkg::CLS_DISK, 64'd99);
        send_charge(rbm_pkg::CLS_NETWORK, 64'd2);
        send_charge(rbm_pkg::CLS_NETWORK, '0);
        send_charge(rbm_pkg::CLS_NETWORK, 64'd1);
        send_charge(rbm_pkg::CLS_COMPUTE, 64'd100);
        send_charge(rbm_pkg::CLS_NONE, ALL_ONES);

        // Directed: cost equal to credit, then check priority of refusals
        wait_drained();
        write_reg(rbm_pkg::REG_START_CREDIT, 64'd297);
        end_writes();
        send_charge(rbm_pkg::CLS_DISK, 64'd99);
        send_charge(rbm_pkg::CLS_DISK, 64'd1);
        send_charge(rbm_pkg::CLS_NETWORK, 64'd100);
        send_charge(rbm_pkg::CLS_COMPUTE, ALL_ONES);

        // Random: three idling profiles, eight settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 21; snk_idle_pct = 85; end
                1: begin src_idle_pct = 85; snk_idle_pct = 21; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int s = 0; s < 8; s++) begin
                apply_setting(s);
                // back up the pipeline once while requests keep coming
                if (phase == 2 && s == 3)
                    hold_req = 1'b1;
                for (int n = 0; n < 60; n++) begin
                    cls = pick_class();
                    send_charge(cls, pick_amount(cls));
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
